### design/fec23_pkg.sv
package fec23_pkg;

   localparam int DataWidth = 10;
   localparam int ParityWidth = 5;
   localparam int CodewordWidth = DataWidth + ParityWidth;

   localparam logic [1:0] STATUS_CLEAN = 2'd0;
   localparam logic [1:0] STATUS_PARITY_ONLY = 2'd1;
   localparam logic [1:0] STATUS_CORRECTED = 2'd2;
   localparam logic [1:0] STATUS_UNCORRECTABLE = 2'd3;

   typedef struct packed {
      logic [CodewordWidth-1:0] codeword;
      logic                     last_in;
   } req_type;

   typedef struct packed {
      logic [DataWidth-1:0] data_bits;
      logic [1:0]           status;
      logic                 last_out;
   } rsp_type;

   // syndrome produced by a single error on data bit k; parity is linear, so
   // the recomputed parity of any word is the xor of these over its set bits
   localparam logic [ParityWidth-1:0] SYNDROME_TABLE [DataWidth] = '{
      5'd26, 5'd13, 5'd28, 5'd14, 5'd7, 5'd25, 5'd22, 5'd11, 5'd31, 5'd21
   };

   function automatic logic [ParityWidth-1:0] calc_parity(input logic [DataWidth-1:0] data);
      logic [ParityWidth-1:0] acc;
      acc = '0;
      for (int k = 0; k < DataWidth; k++) begin
         if (data[k]) begin
            acc = acc ^ SYNDROME_TABLE[k];
         end
      end
      return acc;
   endfunction

   // received parity r0..r4 sits in codeword bits 10..14; r0 packs to the msb
   function automatic logic [ParityWidth-1:0] pack_rx(input logic [ParityWidth-1:0] rx);
      logic [ParityWidth-1:0] packed_rx;
      for (int k = 0; k < ParityWidth; k++) begin
         packed_rx[ParityWidth-1-k] = rx[k];
      end
      return packed_rx;
   endfunction

   function automatic rsp_type decode(input req_type item);
      rsp_type                res;
      logic [DataWidth-1:0]   data;
      logic [ParityWidth-1:0] syn;
      logic [2:0]             weight;
      logic [DataWidth-1:0]   hit;
      data = item.codeword[DataWidth-1:0];
      syn = calc_parity(data) ^ pack_rx(item.codeword[CodewordWidth-1:DataWidth]);
      weight = 3'($countones(syn));
      for (int k = 0; k < DataWidth; k++) begin
         hit[k] = (syn == SYNDROME_TABLE[k]);
      end
      res.last_out = item.last_in;
      res.data_bits = data;
      if (weight == 3'd0) begin
         res.status = STATUS_CLEAN;
      end else if (weight == 3'd1) begin
         res.status = STATUS_PARITY_ONLY;
      end else if (hit != '0) begin
         res.status = STATUS_CORRECTED;
         res.data_bits = data ^ hit;
      end else begin
         res.status = STATUS_UNCORRECTABLE;
      end
      return res;
   endfunction

endpackage

### design/fec23_block_decoder_top.sv
// Block decoder for the rate-2/3 shortened (15,10) Hamming code.
// Input channel (req_valid/req_ready/req_data): one 15-bit codeword per
// transfer, data bits in [9:0], received parity in [14:10], plus a last flag.
// Result channel (rsp_valid/rsp_ready/rsp_data): one result per codeword with
// the ten decoded data bits, a 2-bit status (clean, parity-only mismatch,
// data bit corrected, uncorrectable) and the copied last flag.
// Path: an accepted codeword goes into the input register, then through the
// decode logic into the result register, which drives rsp.
// Throughput: one codeword per cycle while rsp_ready is high, set by the
// single decode stage.
// Stalls: when rsp_ready is low the result register holds; the input register
// can still take one more codeword, then req_ready drops until the result
// side drains. req_ready depends combinationally on rsp_ready.
// Reset (synchronous, active high) empties both stages; the data registers are not reset.
module fec23_block_decoder_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  fec23_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output fec23_pkg::rsp_type  rsp_data
);
   import fec23_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff, in_item_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff, out_item_in;
   logic    out_load;
   logic    in_load;

   assign out_load = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || out_load;
   assign in_load = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in = in_item_ff;
      if (in_load) begin
         in_valid_in = 1'b1;
         in_item_in = req_data;
      end else if (out_load) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in = out_item_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_item_in = decode(in_item_ff);
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_item_ff <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_item_ff;

   a_empty_input_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input stage empty but not ready");

   a_load_fills_output: assert property (@(posedge clock) disable iff (reset)
      out_load |=> out_valid_ff)
      else $error("decoded transfer lost");

   a_stalled_input_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_load |=> in_valid_ff && $stable(in_item_ff))
      else $error("input stage changed while blocked");

   a_correction_flips_one: assert property (@(posedge clock) disable iff (reset)
      out_load |=> ((out_item_ff.status == STATUS_CORRECTED) ==
                    ($countones(out_item_ff.data_bits ^
                                $past(in_item_ff.codeword[DataWidth-1:0])) == 1)))
      else $error("correction does not flip exactly one data bit");

   a_last_follows: assert property (@(posedge clock) disable iff (reset)
      out_load |=> out_item_ff.last_out == $past(in_item_ff.last_in))
      else $error("last flag not carried");

endmodule
